// ===== hw/rtl/fppid_pkg.sv =====
// ----------------------------------------------------------------------------
// fppid_pkg
// Shared types, widths, register indexes and helpers for the fixed-point PID.
// ----------------------------------------------------------------------------
package fppid_pkg;

  localparam int FRACTION_BITS = 7;

  localparam int DATA_W    = 16;  // port samples and drive value
  localparam int CLAMP_W   = 15;  // samples after clamping to -16384..16383
  localparam int ERR_W     = 16;  // error and measurement difference
  localparam int GAIN_W    = 15;
  localparam int SUM_LIM_W = 30;
  localparam int CFG_W     = 30;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 31;  // error accumulator, bounded by +-sum_limit
  localparam int SUM_W     = 32;  // accumulator plus error before bounding
  localparam int TOTAL_W   = 33;  // P + I + D at full width

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT   = 3'd4;

  localparam logic [GAIN_W-1:0]    ERROR_LIMIT_RST = 15'h7FFF;
  localparam logic [SUM_LIM_W-1:0] SUM_LIMIT_RST   = 30'h3FFF_FFFF;

  typedef logic [1:0] sat_t;
  localparam sat_t SAT_NONE = 2'd0;
  localparam sat_t SAT_HIGH = 2'd1;
  localparam sat_t SAT_LOW  = 2'd2;

  localparam logic signed [DATA_W-1:0] P_SAT_HIGH = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] P_SAT_LOW  = 16'sh8000;
  localparam logic signed [SUM_W-1:0]  I_SAT_HIGH = 32'sh3FFF_FFFF;
  localparam logic signed [SUM_W-1:0]  I_SAT_LOW  = 32'shC000_0000;

  typedef struct packed {
    logic [GAIN_W-1:0]    p_gain;
    logic [GAIN_W-1:0]    i_gain;
    logic [GAIN_W-1:0]    d_gain;
    logic [GAIN_W-1:0]    error_limit;
    logic [SUM_LIM_W-1:0] sum_limit;
  } cfg_t;

  typedef struct packed {
    sat_t                    p_sat;
    logic signed [ERR_W-1:0] err;
    sat_t                    i_sat;
    logic signed [SUM_W-1:0] sum;
    logic signed [ERR_W-1:0] diff;
  } front_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] p_term;
    logic signed [SUM_W-1:0]  i_term;
    logic signed [DATA_W-1:0] d_term;
  } terms_t;

  function automatic logic signed [CLAMP_W-1:0] clamp_sample(
    input logic signed [DATA_W-1:0] x
  );
    logic signed [CLAMP_W-1:0] r;
    if (x[DATA_W-1] && !x[DATA_W-2]) begin
      r = {1'b1, {(CLAMP_W-1){1'b0}}};
    end else if (!x[DATA_W-1] && x[DATA_W-2]) begin
      r = {1'b0, {(CLAMP_W-1){1'b1}}};
    end else begin
      r = x[CLAMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fixed_point_pid_controller.sv =====
// ----------------------------------------------------------------------------
// fixed_point_pid_controller
// Discrete PID controller in 9.7 fixed point, one drive value per sample.
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, in_target_value,       request in
//            in_measured_value
//   out      out_valid/out_ready, out_drive_value      request out
//   cfg      cfg_we, cfg_index, cfg_wdata              write only
//
// One request per cycle sustained while out_ready stays high. The front, multiply
// and sum/scale registers load in that order, and out_valid rises as the
// sum/scale register loads.
// Integrator and previous measurement update when a request is accepted.
// Synchronous active-low reset clears state, valids and loads register reset
// values. A stalled out holds the pipeline stage by stage; bubbles collapse.
// ----------------------------------------------------------------------------
module fixed_point_pid_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fppid_pkg::DATA_W-1:0] in_target_value,
  input  logic signed [fppid_pkg::DATA_W-1:0] in_measured_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fppid_pkg::DATA_W-1:0] out_drive_value,
  input  logic                                cfg_we,
  input  logic [fppid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fppid_pkg::CFG_W-1:0]         cfg_wdata
);
  import fppid_pkg::*;

  cfg_t   cfg;
  front_t front;
  terms_t terms;
  logic   front_valid;
  logic   front_ready;
  logic   terms_valid;
  logic   terms_ready;

  fppid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fppid_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .target_value   (in_target_value),
    .measured_value (in_measured_value),
    .front_valid    (front_valid),
    .front_ready    (front_ready),
    .front          (front)
  );

  fppid_terms u_terms (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .front_valid (front_valid),
    .front_ready (front_ready),
    .front       (front),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms)
  );

  fppid_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive_value (out_drive_value)
  );

endmodule

// ===== hw/rtl/fppid_cfg.sv =====
// ----------------------------------------------------------------------------
// fppid_cfg
// Gain and limit registers, written through the plain configuration port.
// ----------------------------------------------------------------------------
module fppid_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fppid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fppid_pkg::CFG_W-1:0]     cfg_wdata,
  output fppid_pkg::cfg_t                 cfg
);
  import fppid_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain      <= '0;
      cfg_r.i_gain      <= '0;
      cfg_r.d_gain      <= '0;
      cfg_r.error_limit <= ERROR_LIMIT_RST;
      cfg_r.sum_limit   <= SUM_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_P_GAIN:      cfg_r.p_gain      <= cfg_wdata[GAIN_W-1:0];
        REG_I_GAIN:      cfg_r.i_gain      <= cfg_wdata[GAIN_W-1:0];
        REG_D_GAIN:      cfg_r.d_gain      <= cfg_wdata[GAIN_W-1:0];
        REG_ERROR_LIMIT: cfg_r.error_limit <= cfg_wdata[GAIN_W-1:0];
        REG_SUM_LIMIT:   cfg_r.sum_limit   <= cfg_wdata[SUM_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/fppid_front.sv =====
// ----------------------------------------------------------------------------
// fppid_front
// Input stage: clamps samples, forms error, bounds the integrator and keeps
// the previous measurement.
// ----------------------------------------------------------------------------
module fppid_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fppid_pkg::cfg_t                    cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [fppid_pkg::DATA_W-1:0] target_value,
  input  logic signed [fppid_pkg::DATA_W-1:0] measured_value,
  output logic                               front_valid,
  input  logic                               front_ready,
  output fppid_pkg::front_t                  front
);
  import fppid_pkg::*;

  logic                      valid_r;
  front_t                    front_r;
  front_t                    front_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [CLAMP_W-1:0] prev_r;
  logic signed [CLAMP_W-1:0] tgt;
  logic signed [CLAMP_W-1:0] meas;
  logic signed [ERR_W-1:0]   elim;
  logic signed [SUM_W-1:0]   slim;
  logic signed [ACC_W-1:0]   slim_acc;
  logic                      accept;

  assign in_ready = !valid_r || front_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    tgt      = clamp_sample(target_value);
    meas     = clamp_sample(measured_value);
    elim     = {1'b0, cfg.error_limit};
    slim     = {2'b00, cfg.sum_limit};
    slim_acc = {1'b0, cfg.sum_limit};

    front_nxt.err  = {tgt[CLAMP_W-1], tgt} - {meas[CLAMP_W-1], meas};
    front_nxt.diff = {prev_r[CLAMP_W-1], prev_r} - {meas[CLAMP_W-1], meas};
    front_nxt.sum  = {acc_r[ACC_W-1], acc_r}
                   + {{(SUM_W-ERR_W){front_nxt.err[ERR_W-1]}}, front_nxt.err};

    if (front_nxt.err > elim) begin
      front_nxt.p_sat = SAT_HIGH;
    end else if (front_nxt.err < -elim) begin
      front_nxt.p_sat = SAT_LOW;
    end else begin
      front_nxt.p_sat = SAT_NONE;
    end

    if (front_nxt.sum > slim) begin
      front_nxt.i_sat = SAT_HIGH;
      acc_nxt         = slim_acc;
    end else if (front_nxt.sum < -slim) begin
      front_nxt.i_sat = SAT_LOW;
      acc_nxt         = -slim_acc;
    end else begin
      front_nxt.i_sat = SAT_NONE;
      acc_nxt         = front_nxt.sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      acc_r   <= '0;
      prev_r  <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (accept) begin
        acc_r  <= acc_nxt;
        prev_r <= meas;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_r <= front_nxt;
    end
  end

  assign front_valid = valid_r;
  assign front       = front_r;

endmodule

// ===== hw/rtl/fppid_terms.sv =====
// ----------------------------------------------------------------------------
// fppid_terms
// Gain multiplies for the P, I and D terms, with saturation values for P and I.
// ----------------------------------------------------------------------------
module fppid_terms (
  input  logic              clk,
  input  logic              rst_n,
  input  fppid_pkg::cfg_t   cfg,
  input  logic              front_valid,
  output logic              front_ready,
  input  fppid_pkg::front_t front,
  output logic              terms_valid,
  input  logic              terms_ready,
  output fppid_pkg::terms_t terms
);
  import fppid_pkg::*;

  logic               valid_r;
  terms_t             terms_r;
  terms_t             terms_nxt;
  logic [DATA_W-1:0]  p_prod;
  logic [SUM_W-1:0]   i_prod;
  logic [DATA_W-1:0]  d_prod;
  logic               load;

  assign front_ready = !valid_r || terms_ready;
  assign load        = front_valid && front_ready;

  // products wrap: only the low bits are kept
  always_comb begin
    p_prod = {1'b0, cfg.p_gain} * front.err;
    d_prod = {1'b0, cfg.d_gain} * front.diff;
    i_prod = {{(SUM_W-GAIN_W){1'b0}}, cfg.i_gain} * front.sum;

    case (front.p_sat)
      SAT_HIGH: terms_nxt.p_term = P_SAT_HIGH;
      SAT_LOW:  terms_nxt.p_term = P_SAT_LOW;
      default:  terms_nxt.p_term = p_prod;
    endcase

    case (front.i_sat)
      SAT_HIGH: terms_nxt.i_term = I_SAT_HIGH;
      SAT_LOW:  terms_nxt.i_term = I_SAT_LOW;
      default:  terms_nxt.i_term = i_prod;
    endcase

    terms_nxt.d_term = d_prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (front_ready) begin
      valid_r <= front_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms_valid = valid_r;
  assign terms       = terms_r;

endmodule

// ===== hw/rtl/fppid_out.sv =====
// ----------------------------------------------------------------------------
// fppid_out
// Sums the terms, scales down by the fraction bits toward zero and saturates
// into the result register.
// ----------------------------------------------------------------------------
module fppid_out (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                terms_valid,
  output logic                                terms_ready,
  input  fppid_pkg::terms_t                   terms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fppid_pkg::DATA_W-1:0] drive_value
);
  import fppid_pkg::*;

  localparam int QUOT_W = TOTAL_W - FRACTION_BITS;
  localparam logic signed [TOTAL_W-1:0] ROUND_BIAS = TOTAL_W'((1 << FRACTION_BITS) - 1);
  localparam logic signed [QUOT_W-1:0]  OUT_MAX = QUOT_W'(32767);
  localparam logic signed [QUOT_W-1:0]  OUT_MIN = -QUOT_W'(32768);

  logic                      valid_r;
  logic signed [DATA_W-1:0]  drive_r;
  logic signed [DATA_W-1:0]  drive_nxt;
  logic signed [TOTAL_W-1:0] total;
  logic signed [TOTAL_W-1:0] biased;
  logic signed [QUOT_W-1:0]  quot;
  logic                      load;

  assign terms_ready = !valid_r || out_ready;
  assign load        = terms_valid && terms_ready;

  always_comb begin
    total  = {{(TOTAL_W-DATA_W){terms.p_term[DATA_W-1]}}, terms.p_term}
           + {{(TOTAL_W-SUM_W){terms.i_term[SUM_W-1]}}, terms.i_term}
           + {{(TOTAL_W-DATA_W){terms.d_term[DATA_W-1]}}, terms.d_term};
    // truncate toward zero
    biased = total[TOTAL_W-1] ? total + ROUND_BIAS : total;
    quot   = biased[TOTAL_W-1:FRACTION_BITS];
    if (quot > OUT_MAX) begin
      drive_nxt = OUT_MAX[DATA_W-1:0];
    end else if (quot < OUT_MIN) begin
      drive_nxt = OUT_MIN[DATA_W-1:0];
    end else begin
      drive_nxt = quot[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (terms_ready) begin
      valid_r <= terms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign drive_value = drive_r;

endmodule

// ===== tb/sv/tb_fixed_point_pid_controller.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_point_pid_controller
// Self-checking bench for the 9.7 fixed-point PID. A directed table of samples
// and register writes comes first, followed by six random phases, each with
// its own gain/limit setting and one of three sender/receiver idle mixes. Every
// accepted request is run through a cycle-free copy of the control law. Drive
// values are checked in order against its predictions or a known table value.
// ----------------------------------------------------------------------------
module tb_fixed_point_pid_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import fppid_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 272;
  localparam int HANG_LIMIT  = 5000;
  localparam int DRAIN_TAIL  = 8;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         wdata;
    logic signed [DATA_W-1:0] tgt;
    logic signed [DATA_W-1:0] meas;
    logic signed [DATA_W-1:0] drive;
  } plan_row_t;

  localparam int PLAN_LEN = 34;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // gains still at reset: everything drives zero
    '{ROW_KNOWN,  REG_P_GAIN,      30'd0,     16'sh7FFF,     16'sh8000,      16'sd0},
    '{ROW_KNOWN,  REG_P_GAIN,      30'd0,     16'sh8000,     16'sh7FFF,      16'sd0},
    // unity P, error bound 100
    '{ROW_WRITE,  REG_P_GAIN,      30'd128,   16'sd0,        16'sd0,         16'sd0},
    '{ROW_WRITE,  REG_ERROR_LIMIT, 30'd100,   16'sd0,        16'sd0,         16'sd0},
    '{ROW_KNOWN,  REG_P_GAIN,      30'd0,     16'sd1000,     16'sd0,         16'sd255},
    '{ROW_KNOWN,  REG_P_GAIN,      30'd0,     -16'sd1000,    16'sd0,         -16'sd256},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd100,      16'sd0,         16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     -16'sd100,     16'sd0,         16'sd0},
    // zero sum bound: any nonzero error pins the integral
    '{ROW_WRITE,  REG_I_GAIN,      30'd32767, 16'sd0,        16'sd0,         16'sd0},
    '{ROW_WRITE,  REG_SUM_LIMIT,   30'd0,     16'sd0,        16'sd0,         16'sd0},
    '{ROW_KNOWN,  REG_P_GAIN,      30'd0,     16'sd10,       16'sd0,         16'sh7FFF},
    '{ROW_KNOWN,  REG_P_GAIN,      30'd0,     -16'sd10,      16'sd0,         16'sh8000},
    '{ROW_KNOWN,  REG_P_GAIN,      30'd0,     16'sd0,        16'sd0,         16'sd0},
    // derivative only, full gain, clamp corners
    '{ROW_WRITE,  REG_P_GAIN,      30'd0,     16'sd0,        16'sd0,         16'sd0},
    '{ROW_WRITE,  REG_I_GAIN,      30'd0,     16'sd0,        16'sd0,         16'sd0},
    '{ROW_WRITE,  REG_D_GAIN,      30'd32767, 16'sd0,        16'sd0,         16'sd0},
    '{ROW_WRITE,  REG_ERROR_LIMIT, 30'd32767, 16'sd0,        16'sd0,         16'sd0},
    '{ROW_WRITE,  REG_SUM_LIMIT,   30'h3FFF_FFFF, 16'sd0,    16'sd0,         16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd0,        16'sd16383,     16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd0,        -16'sd16384,    16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd0,        16'sd16384,     16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd0,        -16'sd16385,    16'sd0},
    // all gains at max: products wrap
    '{ROW_WRITE,  REG_P_GAIN,      30'd32767, 16'sd0,        16'sd0,         16'sd0},
    '{ROW_WRITE,  REG_I_GAIN,      30'd32767, 16'sd0,        16'sd0,         16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd16383,    -16'sd16384,    16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd16383,    -16'sd16384,    16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sh8000,     16'sh7FFF,      16'sd0},
    // zero error bound
    '{ROW_WRITE,  REG_ERROR_LIMIT, 30'd0,     16'sd0,        16'sd0,         16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd5,        16'sd5,         16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd6,        16'sd5,         16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd4,        16'sd5,         16'sd0},
    // unmapped indexes must not touch anything
    '{ROW_WRITE,  REG_SPARE_LO,    30'd12345, 16'sd0,        16'sd0,         16'sd0},
    '{ROW_WRITE,  REG_SPARE_HI,    30'h3FFF_FFFF, 16'sd0,    16'sd0,         16'sd0},
    '{ROW_SAMPLE, REG_P_GAIN,      30'd0,     16'sd1,        16'sd2,         16'sd0}
  };

  localparam logic signed [DATA_W-1:0] CORNERS [9] = '{
    16'sh8000, -16'sd16385, -16'sd16384, -16'sd16383, 16'sd0,
    16'sd16382, 16'sd16383, 16'sd16384, 16'sh7FFF
  };

  logic                     clk               = 1'b0;
  logic                     rst_n             = 1'b0;
  logic                     in_valid          = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_target_value   = '0;
  logic signed [DATA_W-1:0] in_measured_value = '0;
  logic                     out_valid;
  logic                     out_ready         = 1'b0;
  logic signed [DATA_W-1:0] out_drive_value;
  logic                     cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index         = REG_P_GAIN;
  logic [CFG_W-1:0]         cfg_wdata         = '0;

  fixed_point_pid_controller u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_target_value   (in_target_value),
    .in_measured_value (in_measured_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_value   (out_drive_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // controller copy
  cfg_t                     law_cfg;
  int                       integ_sum;
  logic signed [DATA_W-1:0] last_meas;

  logic signed [DATA_W-1:0] drive_expected [$];
  int                       mismatch_count = 0;
  int                       quiet_cycles   = 0;
  int                       send_idle_pct  = 37;
  int                       recv_stall_pct = 88;
  int                       walk_tgt       = 0;
  int                       walk_meas      = 0;

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic void law_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
    case (idx)
      REG_P_GAIN:      law_cfg.p_gain      = data[GAIN_W-1:0];
      REG_I_GAIN:      law_cfg.i_gain      = data[GAIN_W-1:0];
      REG_D_GAIN:      law_cfg.d_gain      = data[GAIN_W-1:0];
      REG_ERROR_LIMIT: law_cfg.error_limit = data[GAIN_W-1:0];
      REG_SUM_LIMIT:   law_cfg.sum_limit   = data[SUM_LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // advances integrator and previous measurement, returns the drive value
  function automatic logic signed [DATA_W-1:0] pid_predict_drive(
    input logic signed [DATA_W-1:0] tgt_in,
    input logic signed [DATA_W-1:0] meas_in
  );
    longint      tgt, meas, err, elim, slim, acc, p, i, d, total;
    logic [63:0] prod;
    tgt  = clip(longint'(tgt_in), -16384, 16383);
    meas = clip(longint'(meas_in), -16384, 16383);
    err  = tgt - meas;
    elim = longint'(law_cfg.error_limit);
    slim = longint'(law_cfg.sum_limit);

    if (err > elim) begin
      p = 32767;
    end else if (err < -elim) begin
      p = -32768;
    end else begin
      prod = longint'(law_cfg.p_gain) * err;
      p = longint'($signed(prod[15:0]));
    end

    acc = longint'(integ_sum) + err;
    if (acc > slim) begin
      integ_sum = int'(slim);
      i = 1073741823;
    end else if (acc < -slim) begin
      integ_sum = int'(-slim);
      i = -1073741824;
    end else begin
      integ_sum = int'(acc);
      prod = longint'(law_cfg.i_gain) * acc;
      i = longint'($signed(prod[31:0]));
    end

    prod = longint'(law_cfg.d_gain) * (longint'(last_meas) - meas);
    d = longint'($signed(prod[15:0]));
    last_meas = DATA_W'(meas);

    total = p + i + d;
    return DATA_W'(clip(total / (longint'(1) << FRACTION_BITS), -32768, 32767));
  endfunction

  task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] got,
                                 input logic signed [DATA_W-1:0] want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_sample(input logic signed [DATA_W-1:0] t,
                             input logic signed [DATA_W-1:0] m,
                             input bit use_known,
                             input logic signed [DATA_W-1:0] known);
    logic signed [DATA_W-1:0] pred;
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_target_value   <= t;
    in_measured_value <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = pid_predict_drive(t, m);
    drive_expected.push_back(use_known ? known : pred);
  endtask

  // hold off the sender until every outstanding request has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    law_write(idx, data);
  endtask

  task automatic load_setting();
    int                   style;
    logic [GAIN_W-1:0]    pg, ig, dg, el;
    logic [SUM_LIM_W-1:0] sl;
    style = $urandom_range(0, 3);
    pg = GAIN_W'($urandom_range(0, 32767) >> $urandom_range(0, 14));
    ig = GAIN_W'($urandom_range(0, 32767) >> $urandom_range(0, 14));
    dg = GAIN_W'($urandom_range(0, 32767) >> $urandom_range(0, 14));
    el = GAIN_W'(32767 / (int'(pg) + 1));
    sl = SUM_LIM_W'(1073741823 / (int'(ig) + 1));
    if (style == 0) begin
      pg = $urandom_range(0, 1) ? '1 : '0;
      ig = $urandom_range(0, 1) ? '1 : '0;
      dg = $urandom_range(0, 1) ? '1 : '0;
      el = $urandom_range(0, 1) ? '1 : '0;
      sl = $urandom_range(0, 1) ? '1 : '0;
    end else if (style == 3) begin
      el = GAIN_W'($urandom);
      sl = SUM_LIM_W'($urandom);
    end
    write_reg(REG_P_GAIN,      CFG_W'(pg));
    write_reg(REG_I_GAIN,      CFG_W'(ig));
    write_reg(REG_D_GAIN,      CFG_W'(dg));
    write_reg(REG_ERROR_LIMIT, CFG_W'(el));
    write_reg(REG_SUM_LIMIT,   CFG_W'(sl));
  endtask

  // mostly a plant tracking its setpoint, plus full-range noise and corners
  task automatic next_sample(output logic signed [DATA_W-1:0] t,
                             output logic signed [DATA_W-1:0] m);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      t = DATA_W'($urandom);
      m = DATA_W'($urandom);
    end else if (pick == 2) begin
      t = CORNERS[$urandom_range(0, 8)];
      m = CORNERS[$urandom_range(0, 8)];
    end else begin
      if ($urandom_range(0, 15) == 0) walk_tgt = int'($urandom_range(0, 32767)) - 16384;
      walk_meas = walk_meas + (walk_tgt - walk_meas) / 8 + int'($urandom_range(0, 64)) - 32;
      walk_meas = int'(clip(walk_meas, -16384, 16383));
      t = DATA_W'(walk_tgt);
      m = DATA_W'(walk_meas);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (drive_expected.size() == 0) begin
        report_mismatch("drive_value with no request pending", out_drive_value, 'x);
      end else begin
        if (out_drive_value !== drive_expected[0]) begin
          report_mismatch("drive_value", out_drive_value, drive_expected[0]);
        end
        void'(drive_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= HANG_LIMIT);
    $display("[%0t] no request moved for %0d cycles", $realtime, HANG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic signed [DATA_W-1:0] t, m;
    law_cfg = '{p_gain: '0, i_gain: '0, d_gain: '0,
                error_limit: ERROR_LIMIT_RST, sum_limit: SUM_LIMIT_RST};
    integ_sum = 0;
    last_meas = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_LEN; r++) begin
      case (PLAN[r].kind)
        ROW_WRITE: begin
          drain();
          write_reg(PLAN[r].idx, PLAN[r].wdata);
        end
        ROW_KNOWN:  push_sample(PLAN[r].tgt, PLAN[r].meas, 1'b1, PLAN[r].drive);
        default:    push_sample(PLAN[r].tgt, PLAN[r].meas, 1'b0, '0);
      endcase
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = (ph < 2) ? 37 : (ph < 4) ? 88 : 0;
      recv_stall_pct = (ph < 2) ? 88 : (ph < 4) ? 37 : 0;
      drain();
      load_setting();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        next_sample(t, m);
        push_sample(t, m, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
